// ===== src/scku_pkg.sv =====
package scku_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FEED,
      ST_EMIT
   } state_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CFG_KEY_0_63    = 3'd0,
      CFG_KEY_64_127  = 3'd1,
      CFG_KEY_128_191 = 3'd2,
      CFG_KEY_192_255 = 3'd3,
      CFG_KEY_IS_256  = 3'd4,
      CFG_NONCE       = 3'd5
   } cfg_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int HALF_ROUNDS = 20;
   localparam int HALF_W      = 5;

   // Diagonal constants: sigma for 256-bit keys, tau for 128-bit keys
   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;
   localparam logic [31:0] TAU_1   = 32'h3120646e;
   localparam logic [31:0] TAU_2   = 32'h79622d36;

   // Word index of role r (a, b, c, d) of quarter-round lane j in the column view
   function automatic logic [3:0] lane_idx(input int j, input int r);
      return 4'(5 * j + 4 * r);
   endfunction

   // Rotation for each of the four quarter-round steps
   function automatic int rot_of(input int s);
      int n;
      case (s)
         0:       n = 7;
         1:       n = 9;
         2:       n = 13;
         default: n = 18;
      endcase
      return n;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

endpackage

// ===== src/scku_if.sv =====
interface scku_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       keystream_only;

   modport source (output valid, output data_byte, output keystream_only, input ready);
   modport sink   (input valid, input data_byte, input keystream_only, output ready);
endinterface

interface scku_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== src/stream_cipher_keystream_xor_unit.sv =====
// Salsa20/20 keystream combiner, one byte per item.
// req_ch carries data_byte and keystream_only; rsp_ch returns out_byte, the
// data byte XORed with the next keystream byte, or the keystream byte alone.
// csr_we/csr_index/csr_wdata write the key words, the key size and the nonce;
// a nonce write restarts the block counter and the byte position.
// Write configuration only while no item is in flight.
// Within a block an item is taken every cycle while the output register is
// free or being emptied, and its result is registered into the output
// register. The first item of each 64-byte block waits for block
// generation: load, 20 half rounds (4 steps each, on one shared bank of four
// add-rotate-xor lanes), feed-forward on the same adders and emit. No new
// item is taken while a block is being generated, so sustained throughput
// is set by the shared round unit.
// The output register holds a result while rsp_ch.ready is low; a new item
// is taken only when that register is free or being emptied.
// Reset (synchronous) clears the registers to key 0, 256-bit key size,
// nonce 0, counter 0 and an empty keystream buffer.
module stream_cipher_keystream_xor_unit (
   input  logic                              clock,
   input  logic                              reset,
   scku_req_if.sink                          req_ch,
   scku_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [scku_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [scku_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   scku_pkg::state_type state_ff, state_in;
   logic [1:0]                  step_ff, step_in;
   logic [scku_pkg::HALF_W-1:0] half_ff, half_in;
   logic [6:0]                  pos_ff, pos_in;
   logic [63:0]                 ctr_ff, ctr_in;
   logic [31:0]                 w_ff [16];
   logic [31:0]                 w_in [16];
   logic [31:0]                 upd  [16];
   logic [31:0]                 m    [16];
   logic [31:0]                 op_a [4];
   logic [31:0]                 op_b [4];
   logic [31:0]                 sum  [4];
   logic [7:0]                  hold_data_ff, hold_data_in;
   logic                        hold_only_ff, hold_only_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff;
   logic        key256_ff;

   logic        req_fire, rsp_fire, nonce_wr, rsp_load, out_only;
   logic [7:0]  out_data, ks_byte;
   logic [31:0] ks_word;

   assign req_fire = req_ch.valid & req_ch.ready;
   assign rsp_fire = rsp_valid_ff & rsp_ch.ready;
   assign nonce_wr = csr_we && (csr_index == scku_pkg::CFG_NONCE);

   assign req_ch.ready    = (state_ff == scku_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff   <= '0;
         key1_ff   <= '0;
         key2_ff   <= '0;
         key3_ff   <= '0;
         key256_ff <= 1'b1;
         nonce_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            scku_pkg::CFG_KEY_0_63:    key0_ff   <= csr_wdata;
            scku_pkg::CFG_KEY_64_127:  key1_ff   <= csr_wdata;
            scku_pkg::CFG_KEY_128_191: key2_ff   <= csr_wdata;
            scku_pkg::CFG_KEY_192_255: key3_ff   <= csr_wdata;
            scku_pkg::CFG_KEY_IS_256:  key256_ff <= csr_wdata[0];
            scku_pkg::CFG_NONCE:       nonce_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Build the input matrix from key, nonce and counter
   always_comb begin
      m[0]  = scku_pkg::SIGMA_0;
      m[1]  = key0_ff[31:0];
      m[2]  = key0_ff[63:32];
      m[3]  = key1_ff[31:0];
      m[4]  = key1_ff[63:32];
      m[5]  = key256_ff ? scku_pkg::SIGMA_1 : scku_pkg::TAU_1;
      m[6]  = nonce_ff[31:0];
      m[7]  = nonce_ff[63:32];
      m[8]  = ctr_ff[31:0];
      m[9]  = ctr_ff[63:32];
      m[10] = key256_ff ? scku_pkg::SIGMA_2 : scku_pkg::TAU_2;
      m[11] = key256_ff ? key2_ff[31:0]  : key0_ff[31:0];
      m[12] = key256_ff ? key2_ff[63:32] : key0_ff[63:32];
      m[13] = key256_ff ? key3_ff[31:0]  : key1_ff[31:0];
      m[14] = key256_ff ? key3_ff[63:32] : key1_ff[63:32];
      m[15] = scku_pkg::SIGMA_3;
   end

   // Select operands of the four shared adders
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         op_a[j] = '0;
         op_b[j] = '0;
         for (int s = 0; s < 4; s++) begin
            if (step_ff == 2'(s)) begin
               if (state_ff == scku_pkg::ST_FEED) begin
                  op_a[j] = w_ff[4 * s + j];
                  op_b[j] = m[4 * s + j];
               end else begin
                  op_a[j] = w_ff[scku_pkg::lane_idx(j, s)];
                  op_b[j] = w_ff[scku_pkg::lane_idx(j, s + 3)];
               end
            end
         end
      end
   end

   // Shared adder bank
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sum[j] = op_a[j] + op_b[j];
      end
   end

   // Write back: rotate-xor into the step target, or feed-forward sums
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         upd[i] = w_ff[i];
      end
      for (int s = 0; s < 4; s++) begin
         for (int j = 0; j < 4; j++) begin
            if (step_ff == 2'(s)) begin
               if (state_ff == scku_pkg::ST_FEED) begin
                  upd[4 * s + j] = sum[j];
               end else begin
                  upd[scku_pkg::lane_idx(j, s + 1)] = w_ff[scku_pkg::lane_idx(j, s + 1)]
                     ^ scku_pkg::rotl(sum[j], scku_pkg::rot_of(s));
               end
            end
         end
      end
   end

   // Pick the keystream byte at the current position
   assign ks_word  = w_ff[pos_ff[5:2]];
   assign ks_byte  = ks_word[8 * pos_ff[1:0] +: 8];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      half_in      = half_ff;
      pos_in       = pos_ff;
      ctr_in       = ctr_ff;
      hold_data_in = hold_data_ff;
      hold_only_in = hold_only_ff;
      rsp_load     = 1'b0;
      out_data     = req_ch.data_byte;
      out_only     = req_ch.keystream_only;
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end

      unique case (state_ff)
         scku_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (pos_ff[6]) begin
                  hold_data_in = req_ch.data_byte;
                  hold_only_in = req_ch.keystream_only;
                  state_in     = scku_pkg::ST_LOAD;
               end else begin
                  rsp_load = 1'b1;
                  pos_in   = pos_ff + 7'd1;
               end
            end
         end
         scku_pkg::ST_LOAD: begin
            for (int i = 0; i < 16; i++) begin
               w_in[i] = m[i];
            end
            step_in  = '0;
            half_in  = '0;
            state_in = scku_pkg::ST_ROUND;
         end
         scku_pkg::ST_ROUND: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               // transpose so the next half round is again a column round
               for (int i = 0; i < 16; i++) begin
                  w_in[{i[1:0], i[3:2]}] = upd[i];
               end
               half_in = half_ff + 1'b1;
               if (half_ff == scku_pkg::HALF_W'(scku_pkg::HALF_ROUNDS - 1)) begin
                  state_in = scku_pkg::ST_FEED;
               end
            end else begin
               for (int i = 0; i < 16; i++) begin
                  w_in[i] = upd[i];
               end
            end
         end
         scku_pkg::ST_FEED: begin
            for (int i = 0; i < 16; i++) begin
               w_in[i] = upd[i];
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               pos_in   = '0;
               ctr_in   = ctr_ff + 64'd1;
               state_in = scku_pkg::ST_EMIT;
            end
         end
         scku_pkg::ST_EMIT: begin
            rsp_load = 1'b1;
            out_data = hold_data_ff;
            out_only = hold_only_ff;
            pos_in   = pos_ff + 7'd1;
            state_in = scku_pkg::ST_IDLE;
         end
         default: state_in = scku_pkg::ST_IDLE;
      endcase

      // Restart the stream on a nonce write
      if (nonce_wr) begin
         ctr_in = '0;
         pos_in = 7'd64;
      end

      rsp_byte_in  = out_only ? ks_byte : (out_data ^ ks_byte);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_fire ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scku_pkg::ST_IDLE;
         step_ff      <= '0;
         half_ff      <= '0;
         pos_ff       <= 7'd64;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         half_ff      <= half_in;
         pos_ff       <= pos_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: working matrix / keystream buffer, held item, result
   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in[i];
      end
      hold_data_ff <= hold_data_in;
      hold_only_ff <= hold_only_in;
      if (rsp_load) begin
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   // An item that finds the buffer empty starts block generation
   a_empty_starts_block: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_ff[6]) |=> (state_ff == scku_pkg::ST_LOAD))
      else $error("empty buffer did not start a block");

   // Feed-forward end rewinds the position and bumps the counter
   a_feed_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scku_pkg::ST_FEED && step_ff == 2'd3 && !csr_we) |=>
      (state_ff == scku_pkg::ST_EMIT && pos_ff == 7'd0 && ctr_ff == $past(ctr_ff) + 64'd1))
      else $error("block end did not update position and counter");

   // The first byte of a block always finds the output register free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scku_pkg::ST_EMIT) |-> !rsp_valid_ff)
      else $error("emit while output register occupied");

   // Position never runs past the empty mark
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 7'd64)
      else $error("byte position out of range");

endmodule
